/* rtl/core/degree_based_edge_partitioner_unit_assert.svh */
// Assertion macros for the edge partitioner.
`ifndef DEGREE_BASED_EDGE_PARTITIONER_UNIT_ASSERT_SVH
`define DEGREE_BASED_EDGE_PARTITIONER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DBEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DBEP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DBEP_ASSERT_NOW(label, ante, cons)
`define DBEP_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/core/dbep_pkg.sv */
package dbep_pkg;

    localparam logic [1:0] CFG_PARTITION_COUNT = 2'd0;
    localparam logic [1:0] CFG_SEED_FRACTION   = 2'd1;
    localparam logic [1:0] CFG_SHRINK_FACTOR   = 2'd2;
    localparam logic [1:0] CFG_TIE_LFSR_SEED   = 2'd3;

    localparam logic [8:0]  RST_PARTITION_COUNT = 9'd4;
    localparam logic [15:0] RST_SEED_FRACTION   = 16'd32768;
    localparam logic [9:0]  RST_SHRINK_FACTOR   = 10'd1;
    localparam logic [15:0] LFSR_FALLBACK       = 16'd44257;

    localparam logic OP_LOAD_DEGREE = 1'b0;
    localparam logic OP_EDGE        = 1'b1;

    localparam int HASH_W = 26;

    typedef logic [31:0] load_t;

    function automatic logic lfsr_fb(input logic [15:0] s);
        return s[0] ^ s[2] ^ s[3] ^ s[5];
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        return {lfsr_fb(s), s[15:1]};
    endfunction

endpackage

/* rtl/core/degree_based_edge_partitioner_unit.sv */
// After reset the block zeroes the partition load counters with busy high. A
// degree load request gives no result and leaves busy low. An edge request goes,
// from acceptance to the next possible acceptance, through two reads through the
// one read port of the degree memory, two multiply stages, a bit-serial modulo by
// the partition count, and a read-modify-write of the load counter memory. done
// pulses for one cycle with the result; the result cannot be held off and must be
// taken in that cycle.
`include "degree_based_edge_partitioner_unit_assert.svh"

module degree_based_edge_partitioner_unit
    import dbep_pkg::*;
#(
    parameter int VERTEX_COUNT   = 65536,
    parameter int MAX_PARTITIONS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] vertex_u,
    input  logic [15:0] vertex_v,
    input  logic [31:0] degree_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [7:0]  partition_id,
    output logic [31:0] partition_load,
    output logic [31:0] lowest_load,
    output logic [31:0] highest_load
);

    localparam int VA_W = $clog2(VERTEX_COUNT);
    localparam int P_W  = $clog2(MAX_PARTITIONS);
    localparam int D_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int U_W  = (D_W > 9) ? D_W : 9;
    localparam int C_W  = $clog2(HASH_W);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RDV   = 4'd2;
    localparam logic [3:0] ST_SEL   = 4'd3;
    localparam logic [3:0] ST_MUL1  = 4'd4;
    localparam logic [3:0] ST_MUL2  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_LD    = 4'd7;
    localparam logic [3:0] ST_UPD   = 4'd8;

    logic [3:0]  state_reg;
    logic [8:0]  pcount_reg;
    logic [15:0] seed_reg;
    logic [9:0]  shrink_reg;
    logic [15:0] lfsr_reg;
    logic [P_W-1:0] clr_reg;
    logic [15:0] vv_reg;
    logic        u_ok_reg;
    logic        v_ok_reg;
    logic [31:0] du_reg;
    logic [15:0] vsel_reg;
    logic [31:0] prod1_reg;
    logic [HASH_W-1:0] quo_reg;
    logic [D_W-1:0] rem_reg;
    logic [C_W-1:0] cnt_reg;
    load_t       min_reg;
    load_t       max_reg;
    logic        done_reg;
    logic [P_W-1:0] pid_reg;
    load_t       load_reg;

    logic        accept;
    logic        u_ok;
    logic        v_ok;
    logic        deg_we;
    logic [VA_W-1:0] deg_raddr;
    logic [31:0] deg_rdata;
    logic [31:0] du;
    logic [31:0] dv;
    logic        tie_fb;
    logic [15:0] vsel_next;
    logic [41:0] prod2;
    logic [U_W-1:0] used_w;
    logic [D_W-1:0] used;
    logic [D_W:0]   rem_try;
    logic [D_W-1:0] rem_next;
    logic        lc_we;
    logic [P_W-1:0] lc_addr;
    load_t       lc_wdata;
    load_t       lc_rdata;
    load_t       load_next;
    load_t       min_next;
    load_t       max_next;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign u_ok   = {16'd0, vertex_u} < 32'(VERTEX_COUNT);
    assign v_ok   = {16'd0, vertex_v} < 32'(VERTEX_COUNT);

    assign deg_we    = accept && (opcode == OP_LOAD_DEGREE) && u_ok;
    assign deg_raddr = (state_reg == ST_RDV) ? VA_W'({8'd0, vv_reg}) : VA_W'({8'd0, vertex_u});

    dbep_ram #(
        .WIDTH (32),
        .DEPTH (VERTEX_COUNT)
    ) u_degree_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (VA_W'({8'd0, vertex_u})),
        .wdata (degree_value),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    assign du     = u_ok_reg ? du_reg : 32'd0;
    assign dv     = v_ok_reg ? deg_rdata : 32'd0;
    assign tie_fb = lfsr_fb(lfsr_reg);

    always_comb
    begin
        if (dv < du)
        begin
            vsel_next = vv_reg;
        end
        else if (du < dv)
        begin
            vsel_next = vsel_reg;
        end
        else
        begin
            vsel_next = tie_fb ? vv_reg : vsel_reg;
        end
    end

    assign prod2 = 42'(prod1_reg) * 42'(shrink_reg);

    always_comb
    begin
        used_w = U_W'(pcount_reg);
        if (used_w == '0)
        begin
            used_w = U_W'(1);
        end
        else if (used_w > U_W'(MAX_PARTITIONS))
        begin
            used_w = U_W'(MAX_PARTITIONS);
        end
    end
    assign used = used_w[D_W-1:0];

    assign rem_try  = {rem_reg, quo_reg[HASH_W-1]};
    assign rem_next = (rem_try >= {1'b0, used}) ? D_W'(rem_try - {1'b0, used})
                                                : rem_try[D_W-1:0];

    assign lc_addr   = (state_reg == ST_CLEAR) ? clr_reg : rem_reg[P_W-1:0];
    assign lc_we     = (state_reg == ST_CLEAR) || (state_reg == ST_UPD);
    assign load_next = (lc_rdata == 32'hFFFF_FFFF) ? lc_rdata : lc_rdata + 32'd1;
    assign lc_wdata  = (state_reg == ST_CLEAR) ? 32'd0 : load_next;
    assign min_next  = (load_next < min_reg) ? load_next : min_reg;
    assign max_next  = (load_next > max_reg) ? load_next : max_reg;

    dbep_ram #(
        .WIDTH (32),
        .DEPTH (MAX_PARTITIONS)
    ) u_load_ram (
        .clk   (clk),
        .we    (lc_we),
        .waddr (lc_addr),
        .wdata (lc_wdata),
        .raddr (lc_addr),
        .rdata (lc_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pcount_reg    <= RST_PARTITION_COUNT;
            seed_reg      <= RST_SEED_FRACTION;
            shrink_reg    <= RST_SHRINK_FACTOR;
            lfsr_reg      <= LFSR_FALLBACK;
            min_reg       <= 32'hFFFF_FFFF;
            max_reg       <= 32'd0;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            done_reg <= (state_reg == ST_UPD);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PARTITION_COUNT: pcount_reg <= cfg_data[8:0];
                    CFG_SEED_FRACTION:   seed_reg   <= cfg_data;
                    CFG_SHRINK_FACTOR:   shrink_reg <= cfg_data[9:0];
                    CFG_TIE_LFSR_SEED:
                    begin
                        lfsr_reg <= (cfg_data != 16'd0) ? cfg_data : LFSR_FALLBACK;
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + P_W'(1);
                    if (clr_reg == P_W'(MAX_PARTITIONS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (opcode == OP_EDGE))
                    begin
                        state_reg <= ST_RDV;
                    end
                end
                ST_RDV:  state_reg <= ST_SEL;
                ST_SEL:
                begin
                    if (du == dv)
                    begin
                        lfsr_reg <= lfsr_step(lfsr_reg);
                    end
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + C_W'(1);
                    if (cnt_reg == C_W'(HASH_W - 1))
                    begin
                        state_reg <= ST_LD;
                    end
                end
                ST_LD:   state_reg <= ST_UPD;
                ST_UPD:
                begin
                    min_reg   <= min_next;
                    max_reg   <= max_next;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vsel_reg <= vertex_u;
            vv_reg   <= vertex_v;
            u_ok_reg <= u_ok;
            v_ok_reg <= v_ok;
        end
        if (state_reg == ST_RDV)
        begin
            du_reg <= deg_rdata;
        end
        if (state_reg == ST_SEL)
        begin
            vsel_reg <= vsel_next;
        end
        if (state_reg == ST_MUL1)
        begin
            prod1_reg <= {16'd0, vsel_reg} * {16'd0, seed_reg};
        end
        if (state_reg == ST_MUL2)
        begin
            quo_reg <= prod2[41:16];
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (state_reg == ST_UPD)
        begin
            pid_reg  <= rem_reg[P_W-1:0];
            load_reg <= load_next;
        end
    end

    assign done           = done_reg;
    assign partition_id   = 8'(pid_reg);
    assign partition_load = load_reg;
    assign lowest_load    = min_reg;
    assign highest_load   = max_reg;

    `DBEP_ASSERT_NOW(a_done_after_update, done_reg, $past(state_reg == ST_UPD))
    `DBEP_ASSERT_NOW(a_min_le_max, done_reg, min_reg <= max_reg)
    `DBEP_ASSERT_NOW(a_pid_in_range, done_reg, {1'b0, pid_reg} < (P_W + 1)'(used))
    `DBEP_ASSERT_NXT(a_load_only_one_cycle, accept && (opcode == OP_LOAD_DEGREE), !busy)

endmodule

/* rtl/core/dbep_ram.sv */
module dbep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
